// ----- src/button_alarm_set_and_dimmer_top_defines.svh -----
// Assertion macros for the button decoder and dimmer.
`ifndef BUTTON_ALARM_SET_AND_DIMMER_TOP_DEFINES_SVH
`define BUTTON_ALARM_SET_AND_DIMMER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BASD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BASD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/basd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package basd_pkg;

    localparam int unsigned PIN_HOUR    = 0;
    localparam int unsigned PIN_TOUCH   = 1;
    localparam int unsigned PIN_QUARTER = 3;
    localparam int unsigned PIN_MINUTE  = 4;
    localparam int unsigned PIN_ALARM   = 7;

    localparam logic [7:0] SET_MASK = 8'b0001_1001;

    localparam logic [4:0] HOUR_LAST    = 5'd23;
    localparam logic [5:0] MINUTE_LAST  = 6'd59;
    localparam logic [5:0] QUARTER_STEP = 6'd15;
    localparam logic [5:0] QUARTER_TOP  = 6'd45;

    localparam logic [15:0] DUTY_STEP0 = 16'd2500;
    localparam logic [15:0] DUTY_STEP1 = 16'd14000;
    localparam logic [15:0] DUTY_STEP2 = 16'd28000;
    localparam logic [15:0] DUTY_STEP3 = 16'd45000;
    localparam logic [15:0] DUTY_MAX   = 16'd65535;

    // Next rung of the dimmer ladder above the given level.
    function automatic logic [15:0] next_duty(input logic [15:0] level);
        logic [15:0] rung;
        if (level < DUTY_STEP0) begin
            rung = DUTY_STEP0;
        end else if (level < DUTY_STEP1) begin
            rung = DUTY_STEP1;
        end else if (level < DUTY_STEP2) begin
            rung = DUTY_STEP2;
        end else if (level < DUTY_STEP3) begin
            rung = DUTY_STEP3;
        end else begin
            rung = DUTY_MAX;
        end
        return rung;
    endfunction

endpackage

`default_nettype wire

// ----- src/button_alarm_set_and_dimmer_top.sv -----
// Channel | Direction | Handshake          | Beat contents
// s_      | in        | s_valid / s_ready  | pin_levels, mode_set_alarm
// m_      | out       | m_valid / m_ready  | events, alarm time, duty, timer
//
// One beat in, one beat out; a new beat is taken every cycle while s_ready is high.
// The result is registered: the decode and the store updates sit between the
// input port and the result register.
// s_ready is high whenever the result register is empty or being drained.
// Synchronous active-low reset: pin history to ones, state zero, payload kept.
`timescale 1ns / 1ps
`default_nettype none

`include "button_alarm_set_and_dimmer_top_defines.svh"

module button_alarm_set_and_dimmer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_pin_levels,
    input  wire logic        s_mode_set_alarm,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_alarm_event,
    output logic             m_touch_event,
    output logic             m_display_update,
    output logic [4:0]       m_alarm_hours,
    output logic [5:0]       m_alarm_minutes,
    output logic [12:0]      m_alarm_time,
    output logic             m_duty_write,
    output logic [15:0]      m_duty_value,
    output logic             m_timer_on
);

    logic [7:0]  pin_history_reg;
    logic        phase_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [15:0] duty_reg;
    logic        timer_reg;

    logic        phase_next;
    logic [4:0]  hour_next;
    logic [5:0]  minute_next;
    logic [15:0] duty_next;
    logic        timer_next;
    logic        alarm_ev;
    logic        touch_ev;
    logic        disp;

    logic        m_valid_reg;
    logic        alarm_ev_reg;
    logic        touch_ev_reg;
    logic        disp_reg;
    logic        dwrite_reg;

    logic [7:0]  changed;
    logic        sel_alarm;
    logic        sel_set;
    logic        sel_touch;
    logic        act;
    logic        accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    assign changed   = s_pin_levels ^ pin_history_reg;
    assign sel_alarm = changed[basd_pkg::PIN_ALARM];
    assign sel_set   = !sel_alarm && s_mode_set_alarm && ((changed & basd_pkg::SET_MASK) != 8'd0);
    assign sel_touch = !sel_alarm && !sel_set && changed[basd_pkg::PIN_TOUCH];
    assign act       = !phase_reg;

    always_comb begin
        phase_next  = phase_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        duty_next   = duty_reg;
        timer_next  = timer_reg;
        alarm_ev    = 1'b0;
        touch_ev    = 1'b0;
        disp        = 1'b0;
        if (sel_alarm || sel_set || sel_touch) begin
            // shared phase: act on one change, skip the next
            phase_next = !phase_reg;
        end
        if (sel_alarm) begin
            alarm_ev = act;
        end else if (sel_set) begin
            disp = 1'b1;
            if (act) begin
                if (changed[basd_pkg::PIN_HOUR]) begin
                    hour_next = (hour_reg < basd_pkg::HOUR_LAST) ? hour_reg + 5'd1 : 5'd0;
                end else if (changed[basd_pkg::PIN_QUARTER]) begin
                    minute_next = (minute_reg < basd_pkg::QUARTER_TOP)
                                ? minute_reg + basd_pkg::QUARTER_STEP
                                : minute_reg - basd_pkg::QUARTER_TOP;
                end else begin
                    minute_next = (minute_reg < basd_pkg::MINUTE_LAST)
                                ? minute_reg + 6'd1 : 6'd0;
                end
            end
        end else if (sel_touch && act) begin
            touch_ev = 1'b1;
            if (duty_reg == basd_pkg::DUTY_MAX) begin
                duty_next  = 16'd0;
                timer_next = 1'b0;
            end else begin
                duty_next  = basd_pkg::next_duty(duty_reg);
                timer_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_history_reg <= 8'hFF;
            phase_reg       <= 1'b0;
            hour_reg        <= 5'd0;
            minute_reg      <= 6'd0;
            duty_reg        <= 16'd0;
            timer_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                pin_history_reg <= s_pin_levels;
                phase_reg       <= phase_next;
                hour_reg        <= hour_next;
                minute_reg      <= minute_next;
                duty_reg        <= duty_next;
                timer_reg       <= timer_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on every accepted beat, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            alarm_ev_reg <= alarm_ev;
            touch_ev_reg <= touch_ev;
            disp_reg     <= disp;
            dwrite_reg   <= touch_ev;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_alarm_event    = alarm_ev_reg;
    assign m_touch_event    = touch_ev_reg;
    assign m_display_update = disp_reg;
    assign m_alarm_hours    = hour_reg;
    assign m_alarm_minutes  = minute_reg;
    assign m_alarm_time     = {hour_reg, 2'b00, minute_reg};
    assign m_duty_write     = dwrite_reg;
    assign m_duty_value     = duty_reg;
    assign m_timer_on       = timer_reg;

    `BASD_ASSERT_NOW(a_timer_tracks_duty, m_valid,
        m_timer_on == (m_duty_value != 16'd0), "timer power disagrees with duty level")
    `BASD_ASSERT_NOW(a_one_event, m_valid,
        !(m_alarm_event && m_touch_event) && !(m_display_update && m_alarm_event)
        && !(m_display_update && m_touch_event), "more than one event in a beat")
    `BASD_ASSERT_NOW(a_write_with_touch, m_valid && m_duty_write,
        m_touch_event, "duty write without touch event")
    `BASD_ASSERT_NEXT(a_skip_after_touch, accept && touch_ev && changed[basd_pkg::PIN_TOUCH]
        && !sel_alarm, phase_reg, "phase not advanced after touch press")

endmodule

`default_nettype wire

// ----- bench/tb_button_alarm_set_and_dimmer_top.sv -----
`timescale 1ns / 1ps

module tb_button_alarm_set_and_dimmer_top;

    localparam int ITEM_TARGET = 1300;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 19;
    localparam int STEADY_LO   = 500;
    localparam int STEADY_HI   = 800;

    localparam logic [7:0] HOUR_BIT    = 8'(1 << basd_pkg::PIN_HOUR);
    localparam logic [7:0] TOUCH_BIT   = 8'(1 << basd_pkg::PIN_TOUCH);
    localparam logic [7:0] QUARTER_BIT = 8'(1 << basd_pkg::PIN_QUARTER);
    localparam logic [7:0] MINUTE_BIT  = 8'(1 << basd_pkg::PIN_MINUTE);
    localparam logic [7:0] ALARM_BIT   = 8'(1 << basd_pkg::PIN_ALARM);
    localparam logic [7:0] LIVE_PINS   = HOUR_BIT | TOUCH_BIT | QUARTER_BIT | MINUTE_BIT
                                         | ALARM_BIT;

    typedef struct packed {
        logic [7:0] pins;
        logic       set_mode;
    } pin_sample_t;

    typedef struct packed {
        logic        alarm_event;
        logic        touch_event;
        logic        display_update;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [12:0] packed_time;
        logic        duty_write;
        logic [15:0] duty;
        logic        timer_on;
    } panel_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pin_levels = 8'hFF;
    logic        s_mode_set_alarm = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_alarm_event;
    logic        m_touch_event;
    logic        m_display_update;
    logic [4:0]  m_alarm_hours;
    logic [5:0]  m_alarm_minutes;
    logic [12:0] m_alarm_time;
    logic        m_duty_write;
    logic [15:0] m_duty_value;
    logic        m_timer_on;

    button_alarm_set_and_dimmer_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pin_levels     (s_pin_levels),
        .s_mode_set_alarm (s_mode_set_alarm),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_alarm_event    (m_alarm_event),
        .m_touch_event    (m_touch_event),
        .m_display_update (m_display_update),
        .m_alarm_hours    (m_alarm_hours),
        .m_alarm_minutes  (m_alarm_minutes),
        .m_alarm_time     (m_alarm_time),
        .m_duty_write     (m_duty_write),
        .m_duty_value     (m_duty_value),
        .m_timer_on       (m_timer_on)
    );

    always #5 aclk = ~aclk;

    pin_sample_t pending_samples[$];
    panel_beat_t expected_panel[$];
    int          total_samples = 0;
    int          samples_taken = 0;
    int          errors = 0;
    int          stall_cycles = 0;

    // Shadow of the decoder state
    logic [7:0]  last_pins = 8'hFF;
    logic        press_turn = 1'b0;
    logic [4:0]  alarm_hour = '0;
    logic [5:0]  alarm_minute = '0;
    logic [15:0] dimmer_level = '0;
    logic        dimmer_on = 1'b0;

    logic steady;
    assign steady = samples_taken >= STEADY_LO && samples_taken < STEADY_HI;

    // Flip the shared phase and report whether to act on this change or skip it (release).
    function automatic logic claim_turn();
        logic act;
        act = !press_turn;
        press_turn = !press_turn;
        return act;
    endfunction

    function automatic logic [15:0] rung_above(input logic [15:0] level);
        logic [15:0] rungs[5];
        logic [15:0] pick;
        rungs = '{basd_pkg::DUTY_STEP0, basd_pkg::DUTY_STEP1, basd_pkg::DUTY_STEP2,
                  basd_pkg::DUTY_STEP3, basd_pkg::DUTY_MAX};
        pick = basd_pkg::DUTY_MAX;
        for (int i = 4; i >= 0; i--) begin
            if (level < rungs[i]) pick = rungs[i];
        end
        return pick;
    endfunction

    function automatic panel_beat_t decode_sample(input pin_sample_t smp);
        panel_beat_t beat;
        logic [7:0]  changed;
        beat = '0;
        changed = smp.pins ^ last_pins;
        last_pins = smp.pins;
        if (changed[basd_pkg::PIN_ALARM]) begin
            if (claim_turn()) beat.alarm_event = 1'b1;
        end else if ((changed & basd_pkg::SET_MASK) != 8'h00 && smp.set_mode) begin
            if (changed[basd_pkg::PIN_HOUR]) begin
                if (claim_turn())
                    alarm_hour = (alarm_hour < basd_pkg::HOUR_LAST) ? alarm_hour + 5'd1
                                                                    : 5'd0;
            end else if (changed[basd_pkg::PIN_QUARTER]) begin
                if (claim_turn())
                    alarm_minute = (alarm_minute < basd_pkg::QUARTER_TOP)
                                 ? alarm_minute + basd_pkg::QUARTER_STEP
                                 : alarm_minute - basd_pkg::QUARTER_TOP;
            end else begin
                if (claim_turn())
                    alarm_minute = (alarm_minute < basd_pkg::MINUTE_LAST)
                                 ? alarm_minute + 6'd1 : 6'd0;
            end
            beat.display_update = 1'b1;
        end else if (changed[basd_pkg::PIN_TOUCH]) begin
            if (claim_turn()) begin
                beat.touch_event = 1'b1;
                beat.duty_write = 1'b1;
                if (dimmer_level == basd_pkg::DUTY_MAX) begin
                    dimmer_level = '0;
                    dimmer_on = 1'b0;
                end else begin
                    dimmer_level = rung_above(dimmer_level);
                    dimmer_on = 1'b1;
                end
            end
        end
        beat.hours = alarm_hour;
        beat.minutes = alarm_minute;
        beat.packed_time = {alarm_hour, 2'b00, alarm_minute};
        beat.duty = dimmer_level;
        beat.timer_on = dimmer_on;
        return beat;
    endfunction

    // Driver: take the beat on handshake, then present the next one or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_panel.push_back(decode_sample({s_pin_levels, s_mode_set_alarm}));
                samples_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() > 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    pin_sample_t nxt;
                    nxt = pending_samples.pop_front();
                    s_valid <= 1'b1;
                    s_pin_levels <= nxt.pins;
                    s_mode_set_alarm <= nxt.set_mode;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input int want, input int seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            errors++;
        end
    endtask

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_panel.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual time %0d",
                             $time, m_alarm_time);
                    errors++;
                end else begin
                    panel_beat_t want;
                    want = expected_panel.pop_front();
                    check_field("alarm_event", want.alarm_event, m_alarm_event);
                    check_field("touch_event", want.touch_event, m_touch_event);
                    check_field("display_update", want.display_update, m_display_update);
                    check_field("alarm_hours", want.hours, m_alarm_hours);
                    check_field("alarm_minutes", want.minutes, m_alarm_minutes);
                    check_field("alarm_time", want.packed_time, m_alarm_time);
                    check_field("duty_write", want.duty_write, m_duty_write);
                    check_field("duty_value", want.duty, m_duty_value);
                    check_field("timer_on", want.timer_on, m_timer_on);
                end
            end
            m_ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_button_alarm_set_and_dimmer_top failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    logic [7:0] gen_level = 8'hFF;
    int         live_samples = 0;

    task automatic queue_sample(input logic [7:0] pins, input logic set_mode);
        if (((pins ^ gen_level) & LIVE_PINS) != 8'h00) live_samples++;
        gen_level = pins;
        pending_samples.push_back({pins, set_mode});
        total_samples++;
    endtask

    task automatic queue_press(input logic [7:0] mask, input logic set_mode);
        logic [7:0] rest;
        rest = gen_level;
        queue_sample(rest ^ mask, set_mode);
        queue_sample(rest, set_mode);
    endtask

    initial begin
        int         roll;
        logic [7:0] mask;

        // Directed: idle port, each pin, other pins, set pins out of mode with touch,
        // priority clashes and the lowest three rungs of the dimmer ladder.
        queue_sample(8'hFF, 1'b0);
        queue_press(ALARM_BIT, 1'b0);
        queue_press(8'h64, 1'b1);
        queue_press(basd_pkg::SET_MASK | TOUCH_BIT, 1'b0);
        queue_press(HOUR_BIT, 1'b1);
        queue_press(QUARTER_BIT, 1'b1);
        queue_press(MINUTE_BIT, 1'b1);
        queue_press(basd_pkg::SET_MASK, 1'b1);
        queue_press(ALARM_BIT | TOUCH_BIT, 1'b1);
        queue_press(TOUCH_BIT, 1'b0);
        queue_press(TOUCH_BIT, 1'b1);
        queue_sample(8'h00, 1'b1);
        queue_sample(8'hFF, 1'b1);

        // Random: mostly press/release pairs, the rest noise and lone edges.
        while (live_samples < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                case ($urandom_range(5))
                    0: mask = ALARM_BIT;
                    1: mask = HOUR_BIT;
                    2: mask = QUARTER_BIT;
                    3: mask = MINUTE_BIT;
                    4: mask = TOUCH_BIT;
                    default: mask = 8'($urandom_range(255)) | TOUCH_BIT;
                endcase
                queue_press(mask, $urandom_range(9) != 0);
            end else if (roll < 85) begin
                queue_sample(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                queue_sample(gen_level ^ (8'h01 << $urandom_range(7)), 1'($urandom_range(1)));
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (samples_taken < total_samples) @(posedge aclk);
        while (expected_panel.size() > 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        if (errors == 0) begin
            $display("tb_button_alarm_set_and_dimmer_top passed");
        end else begin
            $display("tb_button_alarm_set_and_dimmer_top failed");
        end
        $finish;
    end

endmodule
